FILE: rtl/rbu_pkg.sv
// Package for the relative bearing unit: widths, angle constants, CORDIC angle table.
// Used by relative_bearing_unit and rbu_cordic. No dependencies.
package rbu_pkg;

    localparam int AngW = 40;
    localparam int TabSize = 24;
    localparam int DefCordicStages = 16;
    localparam int PosW = 32;
    localparam int QW = 16;
    localparam int CordW = 36;
    localparam int OutW = 15;
    localparam logic signed [AngW-1:0] Deg90 = 40'sd377487360;
    localparam logic signed [AngW-1:0] FullCircle = 40'sd1509949440;

    function automatic logic signed [AngW-1:0] atan_entry(input int i);
        logic signed [AngW-1:0] r;
        case (i)
            0: r = 40'sd188743680;
            1: r = 40'sd111421900;
            2: r = 40'sd58872272;
            3: r = 40'sd29884485;
            4: r = 40'sd15000234;
            5: r = 40'sd7507429;
            6: r = 40'sd3754631;
            7: r = 40'sd1877430;
            8: r = 40'sd938729;
            9: r = 40'sd469366;
            10: r = 40'sd234683;
            11: r = 40'sd117342;
            12: r = 40'sd58671;
            13: r = 40'sd29335;
            14: r = 40'sd14668;
            15: r = 40'sd7334;
            16: r = 40'sd3667;
            17: r = 40'sd1833;
            18: r = 40'sd917;
            19: r = 40'sd458;
            20: r = 40'sd229;
            21: r = 40'sd115;
            22: r = 40'sd57;
            23: r = 40'sd29;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/relative_bearing_unit.sv
// Relative bearing unit: computes bearing to another vehicle and heading difference.
// Top level; instantiates three rbu_cordic pipelines and uses rbu_pkg.
//
// Usage: one item per transfer on s_axis (positions and quaternions), one result
// per item on m_axis (valid flag, bearing, heading difference in 1/64 degree).
// Throughput is one item per cycle; the pipeline advances on each cycle in which
// the output register is empty or is being taken, so a stalled receiver freezes
// every stage and no item is lost or repeated. s_axis_tready follows that enable.
// Yaw terms are formed with 16x16 multipliers in two stages, then three parallel
// CORDIC pipelines run, then subtraction, wrap and rounding take two stages.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
module relative_bearing_unit
    import rbu_pkg::*;
#(
    parameter int CORDIC_STAGES = DefCordicStages
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // own_pos_x, own_pos_z, other_pos_x, other_pos_z, own_quat_w/x/y/z,
    // other_quat_w/x/y/z, from the lowest bit up
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position_valid, bearing, heading_difference, zero fill, lowest bit up
    output logic [31:0]  m_axis_tdata
);

    localparam int Lat = CORDIC_STAGES + 4;

    logic en;
    logic [Lat-1:0] vld_reg;
    logic out_vld_reg;
    logic [31:0] out_data_reg;

    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [PosW-1:0] opx, opz, tpx, tpz;
    logic signed [QW-1:0] q [0:7];
    assign opx = s_axis_tdata[31:0];
    assign opz = s_axis_tdata[63:32];
    assign tpx = s_axis_tdata[95:64];
    assign tpz = s_axis_tdata[127:96];
    for (genvar k = 0; k < 8; k++) begin : g_q
        assign q[k] = s_axis_tdata[128 + QW*k +: QW];
    end

    // Stage 1: products and position differences.
    logic signed [PosW:0] dx_reg, dz_reg;
    logic signed [2*QW-1:0] p_reg [0:7];
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= (PosW+1)'(tpx) - (PosW+1)'(opx);
            dz_reg <= (PosW+1)'(tpz) - (PosW+1)'(opz);
            for (int v = 0; v < 2; v++) begin
                p_reg[4*v]   <= q[4*v] * q[4*v+2];
                p_reg[4*v+1] <= q[4*v+1] * q[4*v+3];
                p_reg[4*v+2] <= q[4*v+2] * q[4*v+2];
                p_reg[4*v+3] <= q[4*v+3] * q[4*v+3];
            end
        end
    end

    // Stage 2: yaw vector terms.
    logic signed [CordW-1:0] dx2_reg, dz2_reg, sy_reg [0:1], cy_reg [0:1];
    logic same_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dx2_reg <= CordW'(dx_reg);
            dz2_reg <= CordW'(dz_reg);
            same_reg <= (dx_reg == '0) && (dz_reg == '0);
            for (int v = 0; v < 2; v++) begin
                sy_reg[v] <= (CordW'(p_reg[4*v]) + CordW'(p_reg[4*v+1])) <<< 1;
                cy_reg[v] <= (CordW'(1) <<< 30)
                    - ((CordW'(p_reg[4*v+2]) + CordW'(p_reg[4*v+3])) <<< 1);
            end
        end
    end

    logic signed [AngW-1:0] dir_ang, own_ang, oth_ang;
    rbu_cordic #(.STAGES(CORDIC_STAGES)) u_dir (
        .aclk(aclk), .en(en), .y_in(dx2_reg), .x_in(dz2_reg), .z_out(dir_ang));
    rbu_cordic #(.STAGES(CORDIC_STAGES)) u_own (
        .aclk(aclk), .en(en), .y_in(sy_reg[0]), .x_in(cy_reg[0]), .z_out(own_ang));
    rbu_cordic #(.STAGES(CORDIC_STAGES)) u_oth (
        .aclk(aclk), .en(en), .y_in(sy_reg[1]), .x_in(cy_reg[1]), .z_out(oth_ang));

    logic [CORDIC_STAGES:0] same_dly_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            same_dly_reg <= {same_dly_reg[CORDIC_STAGES-1:0], same_reg};
        end
    end

    // Differences lie within (-2 full, 2 full); wrap with adds.
    logic signed [AngW-1:0] db_reg, dh_reg;
    logic same3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            db_reg <= dir_ang - own_ang;
            dh_reg <= oth_ang - own_ang;
            same3_reg <= same_dly_reg[CORDIC_STAGES];
        end
    end

    function automatic logic [OutW-1:0] wrap_round(input logic signed [AngW-1:0] a);
        logic signed [AngW-1:0] w, wp, wpp, wm;
        logic [AngW-1:0] r;
        wp = a + FullCircle;
        wpp = a + (FullCircle <<< 1);
        wm = a - FullCircle;
        if (a < 0) begin
            w = (wp < 0) ? wpp : wp;
        end else begin
            w = (wm < 0) ? a : wm;
        end
        r = (AngW'(w) + AngW'(32768)) >> 16;
        if (r >= AngW'(23040)) r = '0;
        return r[OutW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (same3_reg) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {1'b0, wrap_round(dh_reg), wrap_round(db_reg), 1'b1};
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = out_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[15:1] < 15'd23040 && m_axis_tdata[30:16] < 15'd23040))
        else $error("angle out of range");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[30:1] == '0)
        else $error("coincident result not zero");

endmodule

FILE: rtl/rbu_cordic.sv
// Pipelined vectoring CORDIC atan2, one micro-rotation per register stage.
// Depends on rbu_pkg for the angle table and widths.
module rbu_cordic
    import rbu_pkg::*;
#(
    parameter int STAGES = DefCordicStages
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [CordW-1:0] y_in,
    input  logic signed [CordW-1:0] x_in,
    output logic signed [AngW-1:0]  z_out
);

    logic signed [CordW:0]   x_reg [0:STAGES];
    logic signed [CordW:0]   y_reg [0:STAGES];
    logic signed [AngW-1:0]  z_reg [0:STAGES];
    logic                    zero_reg [0:STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0] <= (CordW+1)'(y_in);
                    y_reg[0] <= -(CordW+1)'(x_in);
                    z_reg[0] <= Deg90;
                end else begin
                    x_reg[0] <= -(CordW+1)'(y_in);
                    y_reg[0] <= (CordW+1)'(x_in);
                    z_reg[0] <= -Deg90;
                end
            end else begin
                x_reg[0] <= (CordW+1)'(x_in);
                y_reg[0] <= (CordW+1)'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign z_out = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule
